// ===== sv/cse_pkg.sv =====
// Shared types, codes and constants for the cigar segment extractor.
// Used by cse_core, cigar_segment_extractor and cse_checker; depends on nothing.
package cse_pkg;

	localparam int POS_BITS   = 32;
	localparam int FIELD_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int KIND_W     = 2;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 112;

	localparam int IN_START_LO  = 0;
	localparam int IN_MAPPED    = 32;
	localparam int IN_MINUS     = 33;
	localparam int IN_CHAR_LO   = 34;
	localparam int IN_USED_W    = 42;

	localparam int OUT_FIRST_LO  = 0;
	localparam int OUT_SECOND_LO = 32;
	localparam int OUT_STRAND    = 64;
	localparam int OUT_BAD_LO    = 65;
	localparam int OUT_COUNT_LO  = 73;
	localparam int OUT_USED_W    = 105;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
	localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
	localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
	localparam logic [CHAR_W-1:0] CH_S_UP  = 8'h53;
	localparam logic [CHAR_W-1:0] CH_S_LO  = 8'h73;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [FIELD_W-1:0]  field_t;

	typedef enum logic [KIND_W-1:0] {
		IN_READ  = 2'd0,
		IN_CIGAR = 2'd1,
		IN_STATS = 2'd2
	} in_kind_t;

	typedef enum logic [KIND_W-1:0] {
		OUT_EXON     = 2'd0,
		OUT_JUNCTION = 2'd1,
		OUT_BAD_CHAR = 2'd2,
		OUT_STATS    = 2'd3
	} out_kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		field_t            start_position;
		logic              mapped;
		logic              minus_strand;
		logic [CHAR_W-1:0] cigar_char;
	} item_t;

	typedef struct packed {
		out_kind_t         out_kind;
		field_t            first_pos;
		field_t            second_pos;
		logic              strand_bit;
		logic [CHAR_W-1:0] bad_char;
		field_t            read_count;
	} result_t;

	function automatic pos_t field_to_pos(field_t x);
		logic [63:0] w;
		w = 64'(x);
		return w[POS_BITS-1:0];
	endfunction

	function automatic field_t pos_to_field(pos_t p);
		logic [63:0] w;
		w = 64'(p);
		return w[FIELD_W-1:0];
	endfunction

endpackage

// ===== sv/cigar_segment_extractor.sv =====
// Cigar segment extractor top level: input register, step logic, result register.
// Depends on cse_pkg and cse_core.
//
// Takes one item per cycle unless a result is stalled: a begin-read item, a cigar
// character or a statistics request, and returns at most one result item (exon,
// junction, bad character or statistics), which shows from the result register. Each
// item goes through the input register, one pass of step logic (a multiply-by-ten
// accumulate or a position add and compare) and the result register, so a new item
// enters every cycle while the downstream side keeps m_tready high; a stalled
// result holds the input register and, once that is full, drops s_tready.
module cigar_segment_extractor import cse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // start_position, mapped, minus_strand, cigar_char
	input  logic [KIND_W-1:0]     s_tuser,  // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // first_pos, second_pos, strand_bit, bad_char,
	                                        // read_count
	output logic [KIND_W-1:0]     m_tuser   // out_kind
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    adv_s1;
	logic    core_valid;
	result_t core_res;
	item_t   item_in;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_comb begin
		item_in.kind           = s_tuser;
		item_in.start_position = s_tdata[IN_START_LO +: FIELD_W];
		item_in.mapped         = s_tdata[IN_MAPPED];
		item_in.minus_strand   = s_tdata[IN_MINUS];
		item_in.cigar_char     = s_tdata[IN_CHAR_LO +: CHAR_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_in;
	end

	cse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv_s1),
		.item      (item_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= core_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && core_valid)
			res_s2 <= core_res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.out_kind;

	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_FIRST_LO  +: FIELD_W] = res_s2.first_pos;
		m_tdata[OUT_SECOND_LO +: FIELD_W] = res_s2.second_pos;
		m_tdata[OUT_STRAND]               = res_s2.strand_bit;
		m_tdata[OUT_BAD_LO    +: CHAR_W]  = res_s2.bad_char;
		m_tdata[OUT_COUNT_LO  +: FIELD_W] = res_s2.read_count;
	end

endmodule

// ===== sv/cse_core.sv =====
// Per-read state and the single-pass step logic of the cigar segment extractor.
// Depends on cse_pkg.
module cse_core import cse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	pos_t   cursor_q, cursor_d;
	field_t len_q, len_d;
	logic   mapped_q, mapped_d;
	logic   strand_q, strand_d;
	pos_t   min_start_q, min_start_d;
	pos_t   max_end_q, max_end_d;
	field_t reads_q, reads_d;

	pos_t          sp;
	pos_t          end_pos;
	pos_t          end_m1;
	logic          raise;
	logic [35:0]   len_ext;
	logic [35:0]   len_next;

	always_comb begin
		sp       = field_to_pos(item.start_position);
		end_pos  = cursor_q + field_to_pos(len_q);
		end_m1   = end_pos - POS_BITS'(1);
		raise    = (end_pos != '0) && (end_m1 > max_end_q);
		len_ext  = {4'b0, len_q};
		len_next = (len_ext << 3) + (len_ext << 1) + 36'(item.cigar_char - CH_ZERO);
	end

	always_comb begin
		cursor_d    = cursor_q;
		len_d       = len_q;
		mapped_d    = mapped_q;
		strand_d    = strand_q;
		min_start_d = min_start_q;
		max_end_d   = max_end_q;
		reads_d     = reads_q;
		res_valid   = 1'b0;
		res         = '0;
		case (item.kind)
			IN_READ: begin
				if (reads_q != '1)
					reads_d = reads_q + FIELD_W'(1);
				cursor_d = sp;
				len_d    = '0;
				mapped_d = item.mapped;
				strand_d = ~item.minus_strand;
				if (item.mapped && (sp < min_start_q))
					min_start_d = sp;
			end
			IN_STATS: begin
				res_valid      = 1'b1;
				res.out_kind   = OUT_STATS;
				res.first_pos  = pos_to_field(min_start_q);
				res.second_pos = pos_to_field(max_end_q);
				res.read_count = reads_q;
			end
			IN_CIGAR: begin
				if (mapped_q) begin
					if (item.cigar_char inside {[CH_ZERO:CH_NINE]}) begin
						len_d = (len_next[35:32] != '0) ? '1 : len_next[31:0];
					end else begin
						len_d = '0;
						case (item.cigar_char)
							CH_M: begin
								if (raise)
									max_end_d = end_m1;
								cursor_d       = end_pos;
								res_valid      = 1'b1;
								res.out_kind   = OUT_EXON;
								res.first_pos  = pos_to_field(cursor_q);
								res.second_pos = pos_to_field(end_m1);
							end
							CH_N: begin
								if (raise)
									max_end_d = end_m1;
								cursor_d       = end_pos;
								res_valid      = 1'b1;
								res.out_kind   = OUT_JUNCTION;
								res.first_pos  = pos_to_field(cursor_q - POS_BITS'(1));
								res.second_pos = pos_to_field(end_pos);
								res.strand_bit = strand_q;
							end
							CH_D: begin
								if (raise)
									max_end_d = end_m1;
								cursor_d = end_pos;
							end
							CH_I, CH_S_UP, CH_S_LO: begin
								len_d = '0;
							end
							default: begin
								res_valid    = 1'b1;
								res.out_kind = OUT_BAD_CHAR;
								res.bad_char = item.cigar_char;
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			len_q       <= '0;
			mapped_q    <= 1'b0;
			strand_q    <= 1'b1;
			min_start_q <= '1;
			max_end_q   <= '0;
			reads_q     <= '0;
		end else if (step_en) begin
			cursor_q    <= cursor_d;
			len_q       <= len_d;
			mapped_q    <= mapped_d;
			strand_q    <= strand_d;
			min_start_q <= min_start_d;
			max_end_q   <= max_end_d;
			reads_q     <= reads_d;
		end
	end

endmodule

// ===== sv/cse_checker.sv =====
// Port-level checks for the cigar segment extractor, bound to the top level.
// Depends on cse_pkg and cigar_segment_extractor.
module cse_checker import cse_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]     m_tuser
);

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	a_exon_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OUT_EXON) |->
			m_tdata[OUT_USED_W-1:OUT_STRAND] == '0)
		else $error("exon item carries junction, error or count fields");

	a_bad_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OUT_BAD_CHAR) |->
			(m_tdata[OUT_STRAND:0] == '0) && (m_tdata[OUT_USED_W-1:OUT_COUNT_LO] == '0))
		else $error("error item carries position or count fields");

	a_stats_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OUT_STATS) |->
			m_tdata[OUT_COUNT_LO-1:OUT_STRAND] == '0)
		else $error("statistics item carries strand or character fields");

endmodule

bind cigar_segment_extractor cse_checker u_cse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/cse_checker.sv =====
`timescale 1ns / 100ps
// Checker for the cigar segment extractor: watches both item streams, tracks the
// read state, predicts each result item and compares it with what the block returns.
// Depends on cse_pkg.
module cse_tb_checker import cse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // start_position, mapped, minus_strand, cigar_char
	input  logic [KIND_W-1:0]     s_tuser,  // kind
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // first_pos, second_pos, strand_bit, bad_char,
	                                        // read_count
	input  logic [KIND_W-1:0]     m_tuser,  // out_kind
	output int                    mismatch_count,
	output int                    outstanding
);

	pos_t        cur_pos;
	logic [31:0] len_acc;
	logic        rd_mapped;
	logic        rd_plus;
	pos_t        lowest_start;
	pos_t        highest_end;
	logic [31:0] reads_seen;
	result_t     segment_q[$];

	initial begin
		mismatch_count = 0;
		outstanding = 0;
	end

	function automatic string describe(result_t r);
		return $sformatf("kind %0d first %h second %h strand %b char %h count %0d",
			r.out_kind, r.first_pos, r.second_pos, r.strand_bit, r.bad_char, r.read_count);
	endfunction

	function automatic void queue_result(result_t r);
		segment_q.insert(segment_q.size(), r);
	endfunction

	function automatic pos_t advance_cursor();
		pos_t end_pos;
		end_pos = cur_pos + pos_t'(len_acc);
		if (end_pos != '0 && pos_t'(end_pos - pos_t'(1)) > highest_end)
			highest_end = end_pos - pos_t'(1);
		return end_pos;
	endfunction

	task automatic track_alignment(logic [KIND_W-1:0] k, logic [31:0] sp, logic mp, logic mn,
			logic [CHAR_W-1:0] ch);
		result_t     r;
		pos_t        end_pos;
		logic [63:0] wide;
		r = '0;
		case (k)
			IN_READ: begin
				if (reads_seen != '1)
					reads_seen = reads_seen + 1;
				cur_pos = sp;
				len_acc = '0;
				rd_mapped = mp;
				rd_plus = !mn;
				if (mp && sp < lowest_start)
					lowest_start = sp;
			end
			IN_STATS: begin
				r.out_kind = OUT_STATS;
				r.first_pos = lowest_start;
				r.second_pos = highest_end;
				r.read_count = reads_seen;
				queue_result(r);
			end
			IN_CIGAR: if (rd_mapped) begin
				if (ch >= CH_ZERO && ch <= CH_NINE) begin
					wide = 64'(len_acc) * 64'd10 + 64'(ch - CH_ZERO);
					len_acc = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
				end else begin
					case (ch)
						CH_M: begin
							end_pos = advance_cursor();
							r.out_kind = OUT_EXON;
							r.first_pos = cur_pos;
							r.second_pos = end_pos - pos_t'(1);
							cur_pos = end_pos;
							len_acc = '0;
							queue_result(r);
						end
						CH_N: begin
							end_pos = advance_cursor();
							r.out_kind = OUT_JUNCTION;
							r.first_pos = cur_pos - pos_t'(1);
							r.second_pos = end_pos;
							r.strand_bit = rd_plus;
							cur_pos = end_pos;
							len_acc = '0;
							queue_result(r);
						end
						CH_D: begin
							cur_pos = advance_cursor();
							len_acc = '0;
						end
						CH_I, CH_S_UP, CH_S_LO: len_acc = '0;
						default: begin
							len_acc = '0;
							r.out_kind = OUT_BAD_CHAR;
							r.bad_char = ch;
							queue_result(r);
						end
					endcase
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			cur_pos = '0;
			len_acc = '0;
			rd_mapped = 1'b0;
			rd_plus = 1'b1;
			lowest_start = '1;
			highest_end = '0;
			reads_seen = '0;
			segment_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = '0;
				got.out_kind = out_kind_t'(m_tuser);
				got.first_pos = m_tdata[OUT_FIRST_LO +: FIELD_W];
				got.second_pos = m_tdata[OUT_SECOND_LO +: FIELD_W];
				got.strand_bit = m_tdata[OUT_STRAND];
				got.bad_char = m_tdata[OUT_BAD_LO +: CHAR_W];
				got.read_count = m_tdata[OUT_COUNT_LO +: FIELD_W];
				if (segment_q.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result: %s", $realtime, describe(got));
				end else begin
					want = segment_q.pop_front();
					if (got.out_kind !== want.out_kind || got.first_pos !== want.first_pos
							|| got.second_pos !== want.second_pos
							|| got.strand_bit !== want.strand_bit
							|| got.bad_char !== want.bad_char
							|| got.read_count !== want.read_count) begin
						mismatch_count = mismatch_count + 1;
						if (mismatch_count <= 10)
							$display("%0t: expected %s, got %s", $realtime,
								describe(want), describe(got));
					end
				end
			end
			if (s_tvalid && s_tready)
				track_alignment(s_tuser, s_tdata[IN_START_LO +: FIELD_W], s_tdata[IN_MAPPED],
					s_tdata[IN_MINUS], s_tdata[IN_CHAR_LO +: CHAR_W]);
		end
		outstanding = segment_q.size();
	end

endmodule

// ===== sim/cigar_segment_extractor_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the cigar segment extractor: drives directed and random reads
// under several idle patterns and gives the verdict. Depends on cse_pkg, cse_tb_checker
// and cigar_segment_extractor.
module cigar_segment_extractor_tb;
	import cse_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [CHAR_W-1:0] CH_BAD      = 8'h58;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [KIND_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	int                    mismatch_count;
	int                    outstanding;

	int src_idle = 0;
	int sink_stall = 0;
	int items_sent = 0;

	cigar_segment_extractor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	cse_tb_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.mismatch_count(mismatch_count), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall);

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	task automatic push_item(logic [KIND_W-1:0] k, logic [31:0] sp, logic mp, logic mn,
			logic [CHAR_W-1:0] ch);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= IN_DATA_W'({ch, mn, mp, sp});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic push_char(logic [CHAR_W-1:0] ch);
		push_item(IN_CIGAR, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), ch);
	endtask

	task automatic push_read(logic [31:0] sp, logic mp, logic mn);
		push_item(IN_READ, sp, mp, mn, CHAR_W'($urandom_range(255)));
	endtask

	task automatic push_stats();
		push_item(IN_STATS, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
			CHAR_W'($urandom_range(255)));
	endtask

	task automatic push_number(logic [63:0] v);
		string digits;
		digits = $sformatf("%0d", v);
		for (int i = 0; i < digits.len(); i++)
			push_char(digits[i]);
	endtask

	task automatic random_read();
		logic [CHAR_W-1:0] ops[7];
		logic [31:0]       sp;
		logic              mp;
		int                sel;
		int                n_ops;
		ops = '{CH_M, CH_M, CH_N, CH_D, CH_I, CH_S_UP, CH_S_LO};
		sel = $urandom_range(99);
		if (sel < 5) begin
			push_stats();
		end else if (sel < 9) begin
			push_item(KIND_UNUSED, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
				CHAR_W'($urandom_range(255)));
		end else if (sel < 13) begin
			push_char(CHAR_W'($urandom_range(255)));
		end else begin
			case ($urandom_range(9))
				0: sp = '0;
				1: sp = 32'hFFFF_FF00 + $urandom_range(255);
				2: sp = $urandom_range(1000);
				default: sp = $urandom;
			endcase
			mp = ($urandom_range(9) != 0);
			push_read(sp, mp, 1'($urandom_range(1)));
			n_ops = mp ? $urandom_range(1, 6) : $urandom_range(0, 2);
			for (int i = 0; i < n_ops; i++) begin
				if ($urandom_range(3) != 0) begin
					case ($urandom_range(19))
						0: push_number(64'd99999999999);
						1, 2, 3: push_number(64'($urandom));
						default: push_number(64'($urandom_range(300)));
					endcase
				end
				if ($urandom_range(19) == 0)
					push_char(CHAR_W'($urandom_range(255)));
				else
					push_char(ops[$urandom_range(6)]);
			end
		end
	endtask

	initial begin
		int idle_by_phase[4];
		int stall_by_phase[4];
		int target;
		idle_by_phase = '{0, 86, 0, 34};
		stall_by_phase = '{0, 0, 86, 34};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_stats();
		push_number(5);
		push_char(CH_M);
		push_item(KIND_UNUSED, '1, 1'b1, 1'b1, '1);
		push_read('0, 1'b1, 1'b0);
		push_number(0);
		push_char(CH_M);
		push_number(5);
		push_char(CH_N);
		push_char(CH_BAD);
		push_read('1, 1'b0, 1'b1);
		push_number(7);
		push_char(CH_M);
		push_read(32'hFFFF_FFF0, 1'b1, 1'b1);
		push_number(32);
		push_char(CH_N);
		push_number(3);
		push_char(CH_D);
		push_char(CH_I);
		push_char(CH_S_UP);
		push_char(CH_S_LO);
		push_stats();

		target = items_sent;
		for (int p = 0; p < 4; p++) begin
			src_idle = idle_by_phase[p];
			sink_stall = stall_by_phase[p];
			target += 200;
			while (items_sent < target)
				random_read();
			s_tvalid <= 1'b0;
			wait (outstanding == 0);
			@(negedge clk);
		end
		sink_stall = 0;
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
